@@ rtl/cep_pkg.sv @@
// Shared constants, types and register codes for the chirp excitation PWM drive.
package cep_pkg;

  localparam int CEP_DEPTH_DEF = 1024;
  localparam int CEP_TFB_DEF   = 16;
  localparam int CEP_LATENCY   = 11;

  localparam logic [30:0] CEP_Q30_ONE = 31'h4000_0000;

  localparam logic [30:0] CEP_COEF [5] = '{
    31'd1324675879,
    31'd272375560,
    31'd22401992,
    31'd987048,
    31'd27061
  };

  typedef enum logic [2:0] {
    REG_START_FREQ = 3'd0,
    REG_SWEEP_RATE = 3'd1,
    REG_PWM_PERIOD = 3'd2,
    REG_DZ_THRESH  = 3'd3,
    REG_DZ_FLOOR   = 3'd4
  } cep_reg_t;

  localparam logic [15:0] RST_START_FREQ = 16'd128;
  localparam logic [15:0] RST_SWEEP_RATE = 16'd2534;
  localparam logic [15:0] RST_PWM_PERIOD = 16'd1000;
  localparam logic [15:0] RST_DZ_THRESH  = 16'd500;
  localparam logic [15:0] RST_DZ_FLOOR   = 16'd450;

  typedef struct packed {
    logic        valid;
    logic [15:0] x;
    logic        neg;
  } cep_fold_t;

endpackage

@@ rtl/cep_cos_poly.sv @@
// Pipelined quarter-wave cosine: x^2, four Horner stages, final term, round and sign.
module cep_cos_poly
  import cep_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cep_fold_t          fold,
  output logic               duty_valid,
  output logic signed [15:0] duty
);

  logic [30:0]        z_r   [0:4];
  logic               neg_r [0:5];
  logic               v_r   [0:6];
  logic [30:0]        s_r   [1:4];
  logic signed [31:0] c_r;
  logic signed [15:0] duty_r;

  logic [30:0] c_clamp;
  logic [16:0] c_round;
  logic [14:0] c_mag;
  logic [61:0] c_prod;

  always_ff @(posedge clk) begin
    z_r[0]   <= 31'({15'd0, fold.x} * {15'd0, fold.x});
    neg_r[0] <= fold.neg;
  end

  // Horner: s = coef[k] - (z * s) >> 30
  for (genvar j = 1; j <= 4; j++) begin : g_horner
    logic [30:0] prev;
    logic [61:0] prod;
    if (j == 1) begin : g_first
      assign prev = CEP_COEF[4];
    end else begin : g_rest
      assign prev = s_r[j-1];
    end
    assign prod = {31'd0, z_r[j-1]} * {31'd0, prev};
    always_ff @(posedge clk) begin
      s_r[j]   <= CEP_COEF[4-j] - prod[60:30];
      z_r[j]   <= z_r[j-1];
      neg_r[j] <= neg_r[j-1];
    end
  end

  assign c_prod = {31'd0, z_r[4]} * {31'd0, s_r[4]};

  always_ff @(posedge clk) begin
    c_r      <= $signed({1'b0, CEP_Q30_ONE}) - $signed({1'b0, c_prod[60:30]});
    neg_r[5] <= neg_r[4];
  end

  always_comb begin
    c_clamp = c_r[31] ? 31'd0 : c_r[30:0];
    if (c_clamp > CEP_Q30_ONE) c_clamp = CEP_Q30_ONE;
    c_round = 17'((32'(c_clamp) + 32'd16384) >> 15);
    c_mag   = (c_round > 17'd32767) ? 15'h7fff : c_round[14:0];
  end

  always_ff @(posedge clk) begin
    duty_r <= neg_r[5] ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= 6; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= fold.valid;
      for (int i = 1; i <= 6; i++) v_r[i] <= v_r[i-1];
    end
  end

  assign duty_valid = v_r[6];
  assign duty       = duty_r;

endmodule

@@ rtl/chirp_excitation_pwm_drive.sv @@
// Linear chirp excitation generator with PWM compare and direction outputs.
//
// Usage:
//   Input: drive start high with in_sample_time (24-bit time, 2^-TIME_FRACTION_BITS s
//   units). The item is taken at a rising edge with start high and busy low.
//   busy is low whenever rst_n is high, so one item may enter every clock.
//   Output: out_valid strobes for one cycle with duty sample, compare count and
//   direction pins, taken from the last of 11 register stages; one result per item, in order.
//   Throughput: one item per clock, fixed by an 11-stage pipeline: two stages of
//   phase products, a phase sum and quadrant fold, x squared, four Horner stages,
//   the final polynomial term, round and sign, then compare and dead zone.
//   Configuration: APB-style port, registers at byte addresses 0,4,8,12,16
//   (start frequency, sweep rate, PWM period, dead-zone threshold, floor).
//   Write only while no item is in flight. pready is always high.
//   Reset: synchronous, active low; clears the pipeline valid bits and loads the
//   register reset values. busy is high while rst_n is low.
//   The receiver cannot stall; results are on the ports for one cycle only.
module chirp_excitation_pwm_drive
  import cep_pkg::*;
#(
  parameter int COSINE_TABLE_DEPTH = CEP_DEPTH_DEF,
  parameter int TIME_FRACTION_BITS = CEP_TFB_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [23:0]        in_sample_time,
  output logic               out_valid,
  output logic signed [15:0] out_drive_sample,
  output logic [15:0]        out_compare_value,
  output logic               out_pin_clockwise,
  output logic               out_pin_counterclockwise,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PB = 2 * TIME_FRACTION_BITS + 11;
  localparam int AB = $clog2(COSINE_TABLE_DEPTH);
  localparam logic [63:0] PH_OFFSET = 64'd1 << (PB - 2);

  logic [15:0] start_freq_r, sweep_rate_r, pwm_period_r, dz_thresh_r, dz_floor_r;
  cep_reg_t    reg_sel;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cep_reg_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_freq_r <= RST_START_FREQ;
      sweep_rate_r <= RST_SWEEP_RATE;
      pwm_period_r <= RST_PWM_PERIOD;
      dz_thresh_r  <= RST_DZ_THRESH;
      dz_floor_r   <= RST_DZ_FLOOR;
    end else if (wr_en) begin
      case (reg_sel)
        REG_START_FREQ: start_freq_r <= pwdata[15:0];
        REG_SWEEP_RATE: sweep_rate_r <= pwdata[15:0];
        REG_PWM_PERIOD: pwm_period_r <= pwdata[15:0];
        REG_DZ_THRESH:  dz_thresh_r  <= pwdata[15:0];
        REG_DZ_FLOOR:   dz_floor_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_FREQ: prdata = {16'd0, start_freq_r};
      REG_SWEEP_RATE: prdata = {16'd0, sweep_rate_r};
      REG_PWM_PERIOD: prdata = {16'd0, pwm_period_r};
      REG_DZ_THRESH:  prdata = {16'd0, dz_thresh_r};
      REG_DZ_FLOOR:   prdata = {16'd0, dz_floor_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign busy = ~rst_n;

  // stage A: t^2 and linear product
  logic        va_r;
  logic [47:0] tt_r;
  logic [39:0] lin_a_r;

  always_ff @(posedge clk) begin
    tt_r    <= {24'd0, in_sample_time} * {24'd0, in_sample_time};
    lin_a_r <= {24'd0, start_freq_r} * {16'd0, in_sample_time};
  end

  // stage B: sweep rate times t^2, split in halves
  logic        vb_r;
  logic [39:0] qlo_r, qhi_r, lin_b_r;

  always_ff @(posedge clk) begin
    qlo_r   <= {24'd0, sweep_rate_r} * {16'd0, tt_r[23:0]};
    qhi_r   <= {24'd0, sweep_rate_r} * {16'd0, tt_r[47:24]};
    lin_b_r <= lin_a_r;
  end

  // stage C: phase fraction, table index, quadrant fold
  logic [63:0] ph_sum;
  logic [AB-1:0] ph_idx;
  logic [29:0] ph_r;
  logic [30:0] ph_fold;
  cep_fold_t   fold_r;

  always_comb begin
    ph_sum  = 64'(qlo_r) + (64'(qhi_r) << 24) + (64'(lin_b_r) << (TIME_FRACTION_BITS + 2))
            + PH_OFFSET;
    ph_idx  = ph_sum[PB-1 -: AB];
    ph_r    = 30'(ph_idx[AB-3:0]) << (32 - AB);
    ph_fold = ph_idx[AB-2] ? (CEP_Q30_ONE - 31'(ph_r)) : 31'(ph_r);
  end

  always_ff @(posedge clk) begin
    fold_r.x   <= ph_fold[30:15];
    fold_r.neg <= ph_idx[AB-1] ^ ph_idx[AB-2];
    if (!rst_n) begin
      va_r         <= 1'b0;
      vb_r         <= 1'b0;
      fold_r.valid <= 1'b0;
    end else begin
      va_r         <= start & ~busy;
      vb_r         <= va_r;
      fold_r.valid <= vb_r;
    end
  end

  logic               duty_valid;
  logic signed [15:0] duty;

  cep_cos_poly u_poly (
    .clk        (clk),
    .rst_n      (rst_n),
    .fold       (fold_r),
    .duty_valid (duty_valid),
    .duty       (duty)
  );

  // output stage: compare count, dead zone, pins
  logic [14:0] duty_mag;
  logic [30:0] cmp_prod;
  logic [15:0] cmp_val;
  logic        out_valid_r;
  logic signed [15:0] drive_r;
  logic [15:0] cmp_r;
  logic        ccw_r;

  always_comb begin
    duty_mag = duty[15] ? 15'(-duty) : duty[14:0];
    cmp_prod = {15'd0, pwm_period_r} * {16'd0, duty_mag};
    cmp_val  = cmp_prod[30:15];
    if (cmp_val < dz_thresh_r) cmp_val = dz_floor_r;
  end

  always_ff @(posedge clk) begin
    drive_r <= duty;
    cmp_r   <= cmp_val;
    ccw_r   <= (duty > 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= duty_valid;
  end

  assign out_valid                = out_valid_r;
  assign out_drive_sample         = drive_r;
  assign out_compare_value        = cmp_r;
  assign out_pin_counterclockwise = ccw_r;
  assign out_pin_clockwise        = ~ccw_r;

endmodule

@@ rtl/cep_checker.sv @@
// Port-level checker for the chirp excitation PWM drive, bound to the top level.
module cep_checker
  import cep_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_drive_sample,
  input logic               out_pin_clockwise,
  input logic               out_pin_counterclockwise
);

  a_busy_in_reset: assert property (@(posedge clk) !rst_n |-> busy)
    else $error("busy low during reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, CEP_LATENCY))
    else $error("result without matching item");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##CEP_LATENCY out_valid)
    else $error("item lost");

  a_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pin_clockwise != out_pin_counterclockwise) &&
                  (out_pin_counterclockwise == (out_drive_sample > 16'sd0)))
    else $error("direction pins disagree with duty");

endmodule

bind chirp_excitation_pwm_drive cep_checker u_cep_checker (.*);

@@ tb/sv/chirp_excitation_pwm_drive_tb.sv @@
// Self-checking testbench for the chirp excitation PWM drive: directed and random time stamps.
`timescale 1ns / 100ps

module chirp_excitation_pwm_drive_tb;
  import cep_pkg::*;

  localparam int TFB            = CEP_TFB_DEF;
  localparam int PHASE_W        = 2 * TFB + 11;
  localparam int IDX_W          = $clog2(CEP_DEPTH_DEF);
  localparam longint Q30_UNITY  = longint'(CEP_Q30_ONE);
  localparam int WATCHDOG_LIMIT = 4096;

  typedef enum logic [1:0] {GAPS_NONE, GAPS_FULL, GAPS_SPARSE} gap_style_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic [15:0]        cmp;
    logic               cw;
    logic               ccw;
  } chirp_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [23:0]        in_sample_time = '0;
  logic               out_valid;
  logic signed [15:0] out_drive_sample;
  logic [15:0]        out_compare_value;
  logic               out_pin_clockwise;
  logic               out_pin_counterclockwise;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [15:0] start_freq_q = RST_START_FREQ;
  logic [15:0] sweep_rate_q = RST_SWEEP_RATE;
  logic [15:0] period_q     = RST_PWM_PERIOD;
  logic [15:0] dz_thresh_q  = RST_DZ_THRESH;
  logic [15:0] dz_floor_q   = RST_DZ_FLOOR;

  logic [23:0]   pending_times[$];
  chirp_result_t expected_results[$];
  gap_style_t    gap_style = GAPS_NONE;
  int            gap_left = 0;
  int            error_count = 0;
  int            stall_cycles = 0;

  chirp_excitation_pwm_drive dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cos(pi/2 * r / 2^30) in Q15, even Taylor series by Horner
  function automatic longint quarter_wave_cos(input longint r);
    longint x, z, s, c;
    x = r >>> 15;
    z = x * x;
    s = longint'(CEP_COEF[4]);
    for (int k = 3; k >= 0; k--) s = longint'(CEP_COEF[k]) - ((z * s) >>> 30);
    c = Q30_UNITY - ((z * s) >>> 30);
    if (c < 0) c = 0;
    if (c > Q30_UNITY) c = Q30_UNITY;
    c = (c + 16384) >>> 15;
    if (c > 32767) c = 32767;
    return c;
  endfunction

  function automatic chirp_result_t chirp_predict(input logic [23:0] t);
    logic [63:0]   t64, phase_sum;
    logic [31:0]   turn32, angle;
    longint        r, duty, mag, cmp;
    chirp_result_t res;
    t64 = {40'd0, t};
    phase_sum = {48'd0, sweep_rate_q} * (t64 * t64)
              + (({48'd0, start_freq_q} * t64) << (TFB + 2))
              + (64'd1 << (PHASE_W - 2));
    phase_sum &= (64'd1 << PHASE_W) - 64'd1;
    turn32 = 32'(phase_sum >> (PHASE_W - 32));
    angle = (turn32 >> (32 - IDX_W)) << (32 - IDX_W);
    r = longint'(angle[29:0]);
    case (angle[31:30])
      2'd0: duty = quarter_wave_cos(r);
      2'd1: duty = -quarter_wave_cos(Q30_UNITY - r);
      2'd2: duty = -quarter_wave_cos(r);
      default: duty = quarter_wave_cos(Q30_UNITY - r);
    endcase
    mag = (duty < 0) ? -duty : duty;
    cmp = (longint'(period_q) * mag) >>> 15;
    if (cmp < longint'(dz_thresh_q)) cmp = longint'(dz_floor_q);
    res.drive = 16'(duty);
    res.cmp   = 16'(cmp);
    res.cw    = (duty > 0) ? 1'b0 : 1'b1;
    res.ccw   = (duty > 0) ? 1'b1 : 1'b0;
    return res;
  endfunction

  function automatic int draw_gap();
    case (gap_style)
      GAPS_NONE: return 0;
      GAPS_FULL: return $urandom_range(0, 15);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  function automatic logic [15:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic reg_write(input logic [2:0] index, input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {16'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (index)
      REG_START_FREQ: start_freq_q = value;
      REG_SWEEP_RATE: sweep_rate_q = value;
      REG_PWM_PERIOD: period_q     = value;
      REG_DZ_THRESH:  dz_thresh_q  = value;
      REG_DZ_FLOOR:   dz_floor_q   = value;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [15:0] sf, input logic [15:0] sr,
                             input logic [15:0] pp, input logic [15:0] th,
                             input logic [15:0] fl);
    reg_write(REG_START_FREQ, sf);
    reg_write(REG_SWEEP_RATE, sr);
    reg_write(REG_PWM_PERIOD, pp);
    reg_write(REG_DZ_THRESH, th);
    reg_write(REG_DZ_FLOOR, fl);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_times.size() != 0 || start || expected_results.size() != 0);
  endtask

  task automatic queue_random(input int n);
    logic [23:0] t;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: t = 24'($urandom_range(0, 1023));
        1: t = 24'hFFFFFF - 24'($urandom_range(0, 1023));
        default: t = 24'($urandom());
      endcase
      pending_times.push_back(t);
    end
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start) expected_results.push_back(chirp_predict(in_sample_time));
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_times.size() != 0) begin
        start          <= 1'b1;
        in_sample_time <= pending_times.pop_front();
        gap_left       <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    chirp_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with no item pending, drive %0d",
                                  out_drive_sample));
      end else begin
        want = expected_results.pop_front();
        if (out_drive_sample !== want.drive)
          report_mismatch($sformatf("drive_sample got %0d expected %0d",
                                    out_drive_sample, $signed(want.drive)));
        if (out_compare_value !== want.cmp)
          report_mismatch($sformatf("compare_value got %0d expected %0d",
                                    out_compare_value, want.cmp));
        if (out_pin_clockwise !== want.cw)
          report_mismatch($sformatf("pin_clockwise got %b expected %b",
                                    out_pin_clockwise, want.cw));
        if (out_pin_counterclockwise !== want.ccw)
          report_mismatch($sformatf("pin_counterclockwise got %b expected %b",
                                    out_pin_counterclockwise, want.ccw));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("chirp_excitation_pwm_drive regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // reset settings: field extremes and bit patterns
    gap_style = GAPS_NONE;
    pending_times.push_back(24'h000000);
    pending_times.push_back(24'h000001);
    pending_times.push_back(24'hFFFFFF);
    pending_times.push_back(24'hFFFFFE);
    pending_times.push_back(24'h800000);
    pending_times.push_back(24'h7FFFFF);
    pending_times.push_back(24'h555555);
    pending_times.push_back(24'hAAAAAA);
    pending_times.push_back(24'h010000);
    pending_times.push_back(24'h020000);
    pending_times.push_back(24'h00FFFF);
    pending_times.push_back(24'hFF0000);
    pending_times.push_back(24'h000100);
    pending_times.push_back(24'h0F0F0F);
    wait_drained();
    gap_style = GAPS_SPARSE;
    queue_random(150);
    wait_drained();

    // all zero: phase stays at a quarter turn, duty zero, zero period
    load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    for (int i = REG_DZ_FLOOR + 1; i < 8; i++) reg_write(3'(i), 16'($urandom()));
    gap_style = GAPS_FULL;
    pending_times.push_back(24'h000000);
    pending_times.push_back(24'hFFFFFF);
    pending_times.push_back(24'h123456);
    queue_random(5);
    wait_drained();

    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    gap_style = GAPS_NONE;
    queue_random(150);
    wait_drained();

    // zero period into the dead zone
    load_config(16'd777, 16'd3000, 16'd0, 16'd1, 16'hFFFF);
    gap_style = GAPS_SPARSE;
    queue_random(50);
    wait_drained();

    load_config(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    queue_random(50);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      load_config(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                  pick_reg_value(), pick_reg_value());
      gap_style = gap_style_t'(p % 3);
      queue_random(165);
      wait_drained();
    end

    repeat (CEP_LATENCY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("chirp_excitation_pwm_drive regression: pass");
    end else begin
      $display("chirp_excitation_pwm_drive regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cep_pkg.sv
rtl/cep_cos_poly.sv
rtl/chirp_excitation_pwm_drive.sv
rtl/cep_checker.sv
tb/sv/chirp_excitation_pwm_drive_tb.sv
